### hw/rtl/signed_int_to_decimal_ascii_unit_macros.svh
// Assertion macros shared by the decimal conversion unit.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define ITOA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is never true out of reset.
`define ITOA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ITOA_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITOA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/itoa_pkg.sv
// Shared types, constants and the power-of-ten multiple table for the decimal conversion unit.
`timescale 1ns / 1ps
package itoa_pkg;

    localparam int NUM_DIGITS  = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef logic [3:0]  t_digit_idx;
    typedef logic [33:0] t_wide_mag;

    // One conversion job: sign, magnitude and index of the leading digit.
    typedef struct packed {
        logic       neg;
        logic [31:0] mag;
        t_digit_idx top;
    } t_job;

    // Entry [k][d] holds d * 10^k.
    typedef logic [NUM_DIGITS-1:0][NUM_DIGITS-1:0][33:0] t_mult_tab;

    function automatic t_mult_tab build_mult_tab();
        t_mult_tab   tab;
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                tab[k][d] = 34'(p * 64'(d));
            end
            p = p * 64'd10;
        end
        return tab;
    endfunction

    localparam t_mult_tab MULT_TAB = build_mult_tab();

endpackage

### hw/rtl/itoa_front.sv
// Front end: accepts a value, forms sign and magnitude, finds the leading digit position.
`timescale 1ns / 1ps
module itoa_front
    import itoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_vld;
    logic        n_vld;
    logic        r_neg;
    logic [31:0] r_mag;
    logic        accept;
    t_digit_idx  top;

    assign o_stall = r_vld && i_q_full;
    assign o_push  = r_vld && !i_q_full;
    assign accept  = i_valid && !o_stall;
    assign n_vld   = accept || (r_vld && !o_push);

    // Count the powers of ten from 10 upward that are at or below the magnitude.
    always_comb begin
        top = '0;
        for (int j = 1; j < NUM_DIGITS; j++) begin
            top = top + t_digit_idx'({2'b00, r_mag} >= MULT_TAB[j][1]);
        end
    end

    assign o_job = '{neg: r_neg, mag: r_mag, top: top};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_neg <= i_value[31];
            // Two's complement negate in 32 bits keeps the most negative value exact.
            r_mag <= i_value[31] ? (32'd0 - i_value) : i_value;
        end
    end

endmodule

### hw/rtl/itoa_queue.sv
// Two-entry job queue between the front end and the digit generator.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_macros.svh"
module itoa_queue
    import itoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    `ITOA_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ITOA_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `ITOA_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= 2'(QUEUE_DEPTH), "queue count overrun")

endmodule

### hw/rtl/itoa_back.sv
// Back end: emits the sign and one decimal digit per cycle while the output is not stalled, most significant first.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_macros.svh"
module itoa_back
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_character,
    output logic       o_last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    t_state      r_state;
    logic [31:0] r_mag;
    t_digit_idx  r_k;
    logic        r_ovld;
    logic [7:0]  r_char;
    logic        r_last;
    logic        out_free;
    logic        emit;
    t_digit_idx  digit;
    t_wide_mag   wide_mag;
    t_wide_mag   rem;

    assign out_free = !r_ovld || !i_stall;
    assign emit     = (r_state != ST_IDLE) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign wide_mag = {2'b00, r_mag};

    // Digit at position r_k: how many multiples of 10^k fit in the magnitude.
    always_comb begin
        digit = '0;
        for (int j = 1; j < NUM_DIGITS; j++) begin
            digit = digit + t_digit_idx'(wide_mag >= MULT_TAB[r_k][j]);
        end
        rem = wide_mag - MULT_TAB[r_k][digit];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= i_job.neg ? ST_SIGN : ST_DIGIT;
                    end
                end
                ST_SIGN: begin
                    if (emit) begin
                        r_state <= ST_DIGIT;
                    end
                end
                ST_DIGIT: begin
                    if (emit && r_k == '0) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
        if (o_pop) begin
            r_mag <= i_job.mag;
            r_k   <= i_job.top;
        end else if (emit && r_state == ST_DIGIT) begin
            r_mag <= rem[31:0];
            r_k   <= r_k - t_digit_idx'(1);
        end
        if (emit) begin
            if (r_state == ST_SIGN) begin
                r_char <= ASCII_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= ASCII_ZERO + {4'b0000, digit};
                r_last <= (r_k == '0);
            end
        end
    end

    assign o_valid     = r_ovld;
    assign o_character = r_char;
    assign o_last_char = r_last;

    `ITOA_ASSERT(a_k_range, i_clk, i_rst_n, (r_state == ST_IDLE) || (r_k < t_digit_idx'(NUM_DIGITS)), "digit index out of range")
    `ITOA_ASSERT(a_mag_fits, i_clk, i_rst_n, (r_state != ST_DIGIT) || (wide_mag < MULT_TAB[r_k][9] + MULT_TAB[r_k][1]), "magnitude exceeds digit position")
    `ITOA_ASSERT(a_last_ends, i_clk, i_rst_n, (emit && r_state == ST_DIGIT && r_k == '0) |=> (r_state == ST_IDLE), "conversion did not end on last digit")

endmodule

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Top level of the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
// Converts each signed 32-bit value to its decimal text, most significant character first, a
// leading '-' for negative values and a single '0' for zero; the final character of each value
// has o_last_char set. An accepted value is registered in the front end and then queued; the
// back end takes one job from the queue while idle and then produces one character per cycle
// while its output is not stalled, taking no new job until the last character is out, so the
// digit generator sets the sustained rate. A two-entry queue lets the front end keep accepting
// while the back end works, and the output register holds a character while i_stall is high.
module signed_int_to_decimal_ascii_unit
    import itoa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last_char
);

    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    t_job front_job;
    t_job q_job;

    itoa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .i_q_full(q_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    itoa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    itoa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (q_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_last_char(o_last_char)
    );

endmodule

### bench/tb_top.sv
// Self-checking bench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int MAX_REPORTS    = 10;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last_char;

    t_text_char  expected_chars[$];
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len      = 0;

    signed_int_to_decimal_ascii_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    // Push the characters that one value must produce, most significant first.
    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          n;
        t_text_char  c;
        mag = v[31] ? (32'd0 - v) : v;
        n = 0;
        do begin
            digs[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end while (mag != 0 && n < 10);
        if (v[31]) begin
            c.ch = CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch = CHAR_ZERO + 8'(digs[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // Receiver: long hold-off when requested, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len = hold_len - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Predict on each input transaction, check each output transaction.
    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                predict_text(i_value);
            if (o_valid && !i_stall) begin
                got.ch = o_character;
                got.last = o_last_char;
                if (expected_chars.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected char %h last %b at %0t", got.ch, got.last, $time);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want) begin
                        if (fail_count < MAX_REPORTS)
                            $display("mismatch at %0t: expected char %h last %b, got %h last %b",
                                     $time, want.ch, want.last, got.ch, got.last);
                        fail_count++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected character is out.
    task automatic drain_all();
        i_valid <= 1'b0;
        // Let the checker record the last input transaction first.
        @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        logic [31:0] p;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p + $urandom_range(0, 4) - 32'd2;
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) != 0)
            v = 32'd0 - v;
        return v;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[$];
        vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'd2147483647, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd4294967286, 32'd123456789, -32'sd5};
        send_idle_pct = 17;
        recv_idle_pct = 78;
        foreach (vals[i])
            send_value(vals[i]);
        drain_all();
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n)
            send_value(random_value());
        drain_all();
    endtask

    // Hold the output long enough that the queue fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 300;
        repeat (20)
            send_value(random_value());
        drain_all();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(47, 17, 78);
        test_random(47, 78, 17);
        test_random(47, 0, 0);
        test_backpressure();
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
